FILE: sv/vang_pkg.sv
// Shared types, widths and the arctangent table for the full-circle vector angle block.
// No dependencies; every other file imports this package.
package vang_pkg;

  // Field widths and iteration count.
  localparam int COORD_WIDTH = 16;
  localparam int ANGLE_WIDTH = 16;
  localparam int ITERATIONS  = 16;

  // Only this many arctangent steps are tabulated.
  localparam int TABLE_DEPTH = 24;
  localparam int STAGES      = (ITERATIONS < TABLE_DEPTH) ? ITERATIONS : TABLE_DEPTH;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Magnitudes are scaled to 2^39 full scale; growth stays under 2^41.
  localparam int PRE_SHIFT   = 40 - COORD_WIDTH;
  localparam int CDW         = 42;

  // Turn accumulator: 2^32 units per full turn.
  localparam int TURN_BITS   = 32;
  localparam logic [TURN_BITS-1:0] QUARTER_TURN = TURN_BITS'(64'd1 << (TURN_BITS - 2));
  localparam logic [TURN_BITS-1:0] HALF_TURN    = TURN_BITS'(64'd1 << (TURN_BITS - 1));
  localparam logic [TURN_BITS-1:0] ROUND_HALF   = TURN_BITS'(64'd1 << (TURN_BITS - 1 - ANGLE_WIDTH));

  // How the folded angle is placed back on the circle.
  typedef enum logic [2:0] {
    PL_Q1,
    PL_Q2,
    PL_Q3,
    PL_Q4,
    PL_ZERO,
    PL_QUARTER,
    PL_HALF,
    PL_THREE_Q
  } place_t;

  // Data handed from cell to cell.
  typedef struct packed {
    logic signed [CDW-1:0]       cx;
    logic signed [CDW-1:0]       cy;
    logic signed [TURN_BITS-1:0] z;
    place_t                      place;
  } cell_t;

  // atan(2^-i) in turn units, rounded to nearest.
  function automatic logic [TURN_BITS-1:0] stage_angle(input logic [IDX_W-1:0] idx);
    logic [TURN_BITS-1:0] a;
    begin
      case (idx)
        5'd0:    a = 32'd536870912;
        5'd1:    a = 32'd316933406;
        5'd2:    a = 32'd167458907;
        5'd3:    a = 32'd85004756;
        5'd4:    a = 32'd42667331;
        5'd5:    a = 32'd21354465;
        5'd6:    a = 32'd10679838;
        5'd7:    a = 32'd5340245;
        5'd8:    a = 32'd2670163;
        5'd9:    a = 32'd1335087;
        5'd10:   a = 32'd667544;
        5'd11:   a = 32'd333772;
        5'd12:   a = 32'd166886;
        5'd13:   a = 32'd83443;
        5'd14:   a = 32'd41722;
        5'd15:   a = 32'd20861;
        5'd16:   a = 32'd10430;
        5'd17:   a = 32'd5215;
        5'd18:   a = 32'd2608;
        5'd19:   a = 32'd1304;
        5'd20:   a = 32'd652;
        5'd21:   a = 32'd326;
        5'd22:   a = 32'd163;
        5'd23:   a = 32'd81;
        default: a = '0;
      endcase
      return a;
    end
  endfunction

endpackage

FILE: sv/vang_fold.sv
// Input stage: folds the vector into the first quadrant and classifies the axes.
// Depends on vang_pkg.
module vang_fold import vang_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] x,
  input  logic signed [COORD_WIDTH-1:0] y,
  output logic                          out_valid,
  output cell_t                         out_data
);

  logic signed [COORD_WIDTH:0] xe;
  logic signed [COORD_WIDTH:0] ye;
  logic signed [COORD_WIDTH:0] ax;
  logic signed [COORD_WIDTH:0] ay;
  logic                        x_zero;
  logic                        y_zero;
  place_t                      place;
  cell_t                       data_next;

  // Magnitudes, one bit wider so the most negative input fits.
  assign xe     = {x[COORD_WIDTH-1], x};
  assign ye     = {y[COORD_WIDTH-1], y};
  assign ax     = xe[COORD_WIDTH] ? -xe : xe;
  assign ay     = ye[COORD_WIDTH] ? -ye : ye;
  assign x_zero = (x == '0);
  assign y_zero = (y == '0);

  // Pick the quadrant, or an exact axis answer.
  always_comb begin
    if (y_zero && !x[COORD_WIDTH-1]) begin
      place = PL_ZERO;
    end else if (y_zero) begin
      place = PL_HALF;
    end else if (x_zero) begin
      place = y[COORD_WIDTH-1] ? PL_THREE_Q : PL_QUARTER;
    end else if (!x[COORD_WIDTH-1] && !y[COORD_WIDTH-1]) begin
      place = PL_Q1;
    end else if (!y[COORD_WIDTH-1]) begin
      place = PL_Q2;
    end else if (x[COORD_WIDTH-1]) begin
      place = PL_Q3;
    end else begin
      place = PL_Q4;
    end
  end

  // Scale magnitudes up into the working format.
  always_comb begin
    data_next.cx    = CDW'(ax) <<< PRE_SHIFT;
    data_next.cy    = CDW'(ay) <<< PRE_SHIFT;
    data_next.z     = '0;
    data_next.place = place;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: sv/vang_cell.sv
// One CORDIC vectoring step: rotate towards the x axis and accumulate the angle.
// Depends on vang_pkg; the step number arrives on idx and is tied off per cell.
module vang_cell import vang_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [IDX_W-1:0] idx,
  input  logic             in_valid,
  input  cell_t            in_data,
  output logic             out_valid,
  output cell_t            out_data
);

  logic signed [CDW-1:0]       cx;
  logic signed [CDW-1:0]       cy;
  logic signed [CDW-1:0]       dx;
  logic signed [CDW-1:0]       dy;
  logic signed [TURN_BITS-1:0] step;
  logic                        cy_pos;
  cell_t                       data_next;

  assign cx     = in_data.cx;
  assign cy     = in_data.cy;
  // Arithmetic shifts round towards minus infinity.
  assign dx     = cy >>> idx;
  assign dy     = cx >>> idx;
  assign step   = $signed(stage_angle(idx));
  assign cy_pos = !cy[CDW-1] && (cy != '0);

  // Rotate by the sign of y.
  always_comb begin
    data_next.place = in_data.place;
    if (cy_pos) begin
      data_next.cx = cx + dx;
      data_next.cy = cy - dy;
      data_next.z  = in_data.z + step;
    end else begin
      data_next.cx = cx - dx;
      data_next.cy = cy + dy;
      data_next.z  = in_data.z - step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: sv/vang_place.sv
// Output stage: clamps the folded angle, places it in its quadrant and rounds it.
// Depends on vang_pkg.
module vang_place import vang_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  cell_t                  in_data,
  output logic                   out_valid,
  output logic [ANGLE_WIDTH-1:0] out_angle
);

  logic [TURN_BITS-1:0] th;
  logic [TURN_BITS-1:0] turns;
  logic [TURN_BITS-1:0] rounded;

  // Clamp to the first quadrant.
  always_comb begin
    if (in_data.z[TURN_BITS-1]) begin
      th = '0;
    end else if ($unsigned(in_data.z) > QUARTER_TURN) begin
      th = QUARTER_TURN;
    end else begin
      th = $unsigned(in_data.z);
    end
  end

  // Place on the circle; a full turn wraps to zero.
  always_comb begin
    unique case (in_data.place)
      PL_Q1:      turns = th;
      PL_Q2:      turns = HALF_TURN - th;
      PL_Q3:      turns = HALF_TURN + th;
      PL_Q4:      turns = '0 - th;
      PL_ZERO:    turns = '0;
      PL_QUARTER: turns = QUARTER_TURN;
      PL_HALF:    turns = HALF_TURN;
      PL_THREE_Q: turns = HALF_TURN + QUARTER_TURN;
      default:    turns = '0;
    endcase
  end

  // Round to nearest, halves up, and drop the carry out.
  assign rounded = turns + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_angle <= rounded[TURN_BITS-1 -: ANGLE_WIDTH];
    end
  end

endmodule

FILE: sv/full_circle_vector_angle.sv
// Full-circle vector angle: fold, a row of STAGES CORDIC cells (16 by default), place.
// A vector beat passes the fold register, each cell's register and the place register before its angle beat shows.
// Throughput is one beat per cycle; a one-entry skid after the output register catches the
// beat in flight when the output stalls, then the whole row holds until it drains.
// Synchronous reset clears all valid bits and the skid; the data registers are not reset.
module full_circle_vector_angle import vang_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          vec_valid,
  output logic                          vec_stall,
  input  logic signed [COORD_WIDTH-1:0] x,
  input  logic signed [COORD_WIDTH-1:0] y,
  output logic                          angle_valid,
  input  logic                          angle_stall,
  output logic [ANGLE_WIDTH-1:0]        angle
);

  logic                   en;
  logic                   stage_valid [0:STAGES];
  cell_t                  stage_data  [0:STAGES];
  logic                   last_valid;
  logic [ANGLE_WIDTH-1:0] last_angle;
  logic                   skid_full;
  logic [ANGLE_WIDTH-1:0] skid_angle;

  // The row advances whenever the skid is empty.
  assign en        = !skid_full;
  assign vec_stall = skid_full;

  vang_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vec_valid),
    .x         (x),
    .y         (y),
    .out_valid (stage_valid[0]),
    .out_data  (stage_data[0])
  );

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    vang_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .idx       (IDX_W'(i)),
      .in_valid  (stage_valid[i]),
      .in_data   (stage_data[i]),
      .out_valid (stage_valid[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  vang_place u_place (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (stage_valid[STAGES]),
    .in_data   (stage_data[STAGES]),
    .out_valid (last_valid),
    .out_angle (last_angle)
  );

  // Catch the output beat when stalled; drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!angle_stall) begin
        skid_full <= 1'b0;
      end
    end else if (last_valid && angle_stall) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full && last_valid && angle_stall) begin
      skid_angle <= last_angle;
    end
  end

  assign angle_valid = skid_full || last_valid;
  assign angle       = skid_full ? skid_angle : last_angle;

endmodule

FILE: sv/vang_check.sv
// Port-level checks for full_circle_vector_angle, bound to the top level.
// Depends on vang_pkg for field widths.
module vang_check import vang_pkg::*; (
  input logic                          clk,
  input logic                          rst,
  input logic                          vec_valid,
  input logic                          vec_stall,
  input logic signed [COORD_WIDTH-1:0] x,
  input logic signed [COORD_WIDTH-1:0] y,
  input logic                          angle_valid,
  input logic                          angle_stall,
  input logic [ANGLE_WIDTH-1:0]        angle
);

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk) rst |=> !angle_valid)
    else $error("angle beat shown right after reset");

  // A stalled angle beat stays and holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    angle_valid && angle_stall |=> angle_valid && $stable(angle))
    else $error("stalled angle beat changed or vanished");

  // A stalled vector beat stays and holds.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    vec_valid && vec_stall |=> vec_valid && $stable(x) && $stable(y))
    else $error("stalled vector beat changed or vanished");

  // Input back-pressure only follows an output stall.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    vec_stall |-> $past(angle_valid && angle_stall))
    else $error("vector stall without a stalled angle beat before it");

  // While the input is held off, a result is waiting.
  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    vec_stall |-> angle_valid)
    else $error("vector stall with no angle beat waiting");

endmodule

bind full_circle_vector_angle vang_check u_vang_check (
  .clk         (clk),
  .rst         (rst),
  .vec_valid   (vec_valid),
  .vec_stall   (vec_stall),
  .x           (x),
  .y           (y),
  .angle_valid (angle_valid),
  .angle_stall (angle_stall),
  .angle       (angle)
);

FILE: dv/angle_checker.sv
// Checker for the full-circle vector angle block: watches both channels, predicts each angle.
// Depends on vang_pkg for the coordinate and angle widths and the iteration count.
`timescale 1ns / 1ps

module angle_checker import vang_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          vec_valid,
  input  logic                          vec_stall,
  input  logic signed [COORD_WIDTH-1:0] x,
  input  logic signed [COORD_WIDTH-1:0] y,
  input  logic                          angle_valid,
  input  logic                          angle_stall,
  input  logic [ANGLE_WIDTH-1:0]        angle,
  output int                            mismatches,
  output int                            outstanding,
  output int                            checked
);

  // Angle accumulator runs at 2^32 units per turn.
  localparam int                TURN_W     = 32;
  localparam longint unsigned   TURN_FULL  = 64'd1 << TURN_W;
  localparam longint unsigned   TURN_HALF  = 64'd1 << (TURN_W - 1);
  localparam longint unsigned   TURN_QTR   = 64'd1 << (TURN_W - 2);
  localparam longint unsigned   TURN_MASK  = TURN_FULL - 1;
  localparam longint unsigned   ROUND_UP   = 64'd1 << (TURN_W - 1 - ANGLE_WIDTH);
  localparam int                MAG_SHIFT  = 40 - COORD_WIDTH;
  localparam int                ROT_TABLE  = 24;
  localparam int                ROT_COUNT  = (ITERATIONS < ROT_TABLE) ? ITERATIONS : ROT_TABLE;

  // Rotation angles atan(2^-i) in accumulator units.
  localparam longint ROT_ANGLE [ROT_TABLE] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic [ANGLE_WIDTH-1:0] expected_angles [$];
  logic [ANGLE_WIDTH-1:0] want;

  // Vectoring over the folded first-quadrant magnitudes; result clamped to a quarter turn.
  function automatic longint fold_angle(input longint mag_x, input longint mag_y);
    longint cx, cy, dx, dy, acc;
    int     i;
    begin
      cx  = mag_x <<< MAG_SHIFT;
      cy  = mag_y <<< MAG_SHIFT;
      acc = 0;
      for (i = 0; i < ROT_COUNT; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy > 0) begin
          cx  += dx;
          cy  -= dy;
          acc += ROT_ANGLE[i];
        end else begin
          cx  -= dx;
          cy  += dy;
          acc -= ROT_ANGLE[i];
        end
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(TURN_QTR)) acc = longint'(TURN_QTR);
      return acc;
    end
  endfunction

  // Full-circle angle of one vector, rounded to the output width.
  function automatic logic [ANGLE_WIDTH-1:0] predict_angle(
    input logic signed [COORD_WIDTH-1:0] px,
    input logic signed [COORD_WIDTH-1:0] py
  );
    longint          sx, sy;
    longint unsigned th, turns, rounded;
    begin
      sx = px;
      sy = py;
      if (sy == 0 && sx >= 0) begin
        turns = 0;
      end else if (sy == 0) begin
        turns = TURN_HALF;
      end else if (sx == 0) begin
        turns = (sy > 0) ? TURN_QTR : 3 * TURN_QTR;
      end else begin
        th = longint'(fold_angle((sx < 0) ? -sx : sx, (sy < 0) ? -sy : sy));
        if (sx > 0 && sy > 0)
          turns = th;
        else if (sx < 0 && sy > 0)
          turns = TURN_HALF - th;
        else if (sx < 0)
          turns = TURN_HALF + th;
        else
          turns = TURN_FULL - th;
      end
      rounded = ((turns & TURN_MASK) + ROUND_UP) >> (TURN_W - ANGLE_WIDTH);
      return rounded[ANGLE_WIDTH-1:0];
    end
  endfunction

  task automatic report(input string what, input logic [ANGLE_WIDTH-1:0] exp_val,
                        input logic [ANGLE_WIDTH-1:0] got_val);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, exp_val, got_val);
    mismatches++;
  endtask

  // Predict on each vector beat, compare on each angle beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (vec_valid && !vec_stall)
        expected_angles.push_back(predict_angle(x, y));
      if (angle_valid && !angle_stall) begin
        if (expected_angles.size() == 0) begin
          report("angle beat with none outstanding", '0, angle);
        end else begin
          want = expected_angles.pop_front();
          if (angle !== want)
            report("angle", want, angle);
        end
        checked++;
      end
      outstanding = expected_angles.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the full-circle vector angle block: clock, reset, vector and stall stimulus.
// Depends on vang_pkg, full_circle_vector_angle and angle_checker.
`timescale 1ns / 1ps

module tb_top import vang_pkg::*; ();

  localparam int RANDOM_BEATS = 950;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 150;
  localparam int HOLD_AFTER   = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int N_DIRECTED   = 25;

  // Axes, their extremes, corners, the unit diagonals, vectors just off each axis and one general vector.
  localparam int DIR_X [N_DIRECTED] = '{
    0, 1, 32767, -1, -32768, 0, 0, 0, 0, 32767, -32768, -32768, 32767,
    1, -1, -1, 1, 32767, 32767, -32768, -32768, 1, 1, -1, 12345
  };
  localparam int DIR_Y [N_DIRECTED] = '{
    0, 0, 0, 0, 0, 1, 32767, -1, -32768, 32767, 32767, -32768, -32768,
    1, 1, -1, -1, 1, -1, 1, -1, 32767, -32768, -32768, -23456
  };

  typedef enum int {
    VK_FULL, VK_SMALL, VK_NEAR_AXIS, VK_ON_AXIS, VK_DIAGONAL, VK_CORNER
  } vec_kind_t;

  typedef enum int {
    SM_NONE, SM_LIGHT, SM_HEAVY, SM_EVERY_FOURTH
  } stall_mode_t;

  logic                          clk;
  logic                          rst;
  logic                          vec_valid;
  logic                          vec_stall;
  logic signed [COORD_WIDTH-1:0] x;
  logic signed [COORD_WIDTH-1:0] y;
  logic                          angle_valid;
  logic                          angle_stall;
  logic [ANGLE_WIDTH-1:0]        angle;

  int mismatches;
  int outstanding;
  int checked;
  int beats_sent;
  int cycles;
  bit holding;

  full_circle_vector_angle dut (
    .clk         (clk),
    .rst         (rst),
    .vec_valid   (vec_valid),
    .vec_stall   (vec_stall),
    .x           (x),
    .y           (y),
    .angle_valid (angle_valid),
    .angle_stall (angle_stall),
    .angle       (angle)
  );

  angle_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .vec_valid   (vec_valid),
    .vec_stall   (vec_stall),
    .x           (x),
    .y           (y),
    .angle_valid (angle_valid),
    .angle_stall (angle_stall),
    .angle       (angle),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Guard against a hung channel.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d angles outstanding", cycles, outstanding);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one vector beat and hold it until accepted; stall is read mid-cycle.
  task automatic send_vec(input logic signed [COORD_WIDTH-1:0] vx,
                          input logic signed [COORD_WIDTH-1:0] vy);
    logic stalled;
    vec_valid <= 1'b1;
    x         <= vx;
    y         <= vy;
    do begin
      @(negedge clk);
      stalled = vec_stall;
      @(posedge clk);
    end while (stalled);
    beats_sent++;
  endtask

  // Drop valid for a gap.
  task automatic pause(input int gap);
    vec_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic pick_vector(output logic signed [COORD_WIDTH-1:0] vx,
                             output logic signed [COORD_WIDTH-1:0] vy);
    vec_kind_t kind;
    int        r, a, b, m;
    r    = $urandom_range(0, 8);
    kind = (r > VK_CORNER) ? VK_FULL : vec_kind_t'(r);
    a    = $urandom;
    b    = $urandom;
    case (kind)
      VK_SMALL: begin
        a = int'($urandom_range(0, 16)) - 8;
        b = int'($urandom_range(0, 16)) - 8;
      end
      VK_NEAR_AXIS: begin
        if ($urandom_range(0, 1)) a = int'($urandom_range(0, 6)) - 3;
        else                      b = int'($urandom_range(0, 6)) - 3;
      end
      VK_ON_AXIS: begin
        if ($urandom_range(0, 1)) a = 0;
        else                      b = 0;
      end
      VK_DIAGONAL: begin
        m = $urandom_range(1, 32768);
        a = $urandom_range(0, 1) ? m : -m;
        b = $urandom_range(0, 1) ? m : -m;
      end
      VK_CORNER: begin
        case ($urandom_range(0, 5))
          0: a = -32768;  1: a = -32767;  2: a = -1;
          3: a = 0;       4: a = 1;       default: a = 32767;
        endcase
        case ($urandom_range(0, 5))
          0: b = -32768;  1: b = -32767;  2: b = -1;
          3: b = 0;       4: b = 1;       default: b = 32767;
        endcase
      end
      default: ;
    endcase
    vx = a[COORD_WIDTH-1:0];
    vy = b[COORD_WIDTH-1:0];
  endtask

  // Random vectors in bursts; gaps are skipped while the output is held off.
  task automatic run_random(input int count);
    logic signed [COORD_WIDTH-1:0] vx, vy;
    int left, burst, gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        pick_vector(vx, vy);
        send_vec(vx, vy);
        burst--;
        left--;
      end
      gap = (holding || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (left > 0 && gap > 0)
        pause(gap);
    end
  endtask

  // Receiver: stall modes of random length, plus one long hold-off to fill the row.
  initial begin : receiver
    stall_mode_t mode;
    int          span, tick, hold_left;
    bit          held;
    held        = 1'b0;
    tick        = 0;
    angle_stall <= 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(5, 80);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (!held && beats_sent >= HOLD_AFTER) begin
          held    = 1'b1;
          holding = 1'b1;
          for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) begin
            angle_stall <= 1'b1;
            @(posedge clk);
          end
          holding = 1'b0;
        end
        case (mode)
          SM_NONE:         angle_stall <= 1'b0;
          SM_LIGHT:        angle_stall <= ($urandom_range(0, 9) < 3);
          SM_HEAVY:        angle_stall <= ($urandom_range(0, 9) < 7);
          SM_EVERY_FOURTH: angle_stall <= (tick % 4 == 3);
          default:         angle_stall <= 1'b0;
        endcase
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int i;
    rst       <= 1'b1;
    vec_valid <= 1'b0;
    x         <= '0;
    y         <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed vectors, with a few gaps between them.
    for (i = 0; i < N_DIRECTED; i++) begin
      send_vec(DIR_X[i][COORD_WIDTH-1:0], DIR_Y[i][COORD_WIDTH-1:0]);
      if (i % 7 == 6)
        pause($urandom_range(1, 5));
    end

    run_random(RANDOM_BEATS);
    vec_valid <= 1'b0;

    // Drain, then allow the pipeline depth for stray beats.
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d vectors over the axes, corners and all four quadrants; %0d angles",
             beats_sent, checked);
    $display("compared, under bursty input, random output stalls and one long hold-off.");
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
